FILE: rtl/multi_channel_blink_sequencer_defines.svh
// ---------------------------------------------------------------------------
// multi_channel_blink_sequencer assertion macros
// concurrent checks on clk, disabled or empty for synthesis
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_BLINK_SEQUENCER_DEFINES_SVH
`define MULTI_CHANNEL_BLINK_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// check that holds while out of reset
`define MCBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcbs assertion failed");
// check that also covers the reset cycles
`define MCBS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mcbs reset assertion failed");
`else
`define MCBS_ASSERT(lbl, prop)
`define MCBS_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/mcbs_pkg.sv
// ---------------------------------------------------------------------------
// mcbs_pkg
// types, constants and the per-tick channel update of the blink sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package mcbs_pkg;

  localparam int CHANNELS = 3;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LVL_W    = 3;

  localparam logic [7:0] FOREVER = 8'hFF;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SWEEP,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [2:0]  channel;
    logic [7:0]  on_ticks;
    logic [7:0]  off_ticks;
    logic [7:0]  repeat_total;
  } in_t;

  typedef struct packed {
    logic [LVL_W-1:0] output_levels;
    logic             any_active;
  } out_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] ticks_left;
    logic [7:0] on_period;
    logic [7:0] off_period;
    logic [7:0] cycles_left;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // one tick of one channel
  function automatic ent_t mcbs_advance(ent_t e);
    ent_t       r;
    logic [7:0] cyc;
    r   = e;
    cyc = e.cycles_left - 8'd1;
    if (e.phase == PH_ON || e.phase == PH_OFF) begin
      r.ticks_left = e.ticks_left - 8'd1;
      if (r.ticks_left == 8'd0) begin
        if (e.phase == PH_ON) begin
          r.phase = PH_OFF;
          if (e.off_period != 8'd0) begin
            r.ticks_left = e.off_period;
          end
        end
        if (r.phase == PH_OFF && r.ticks_left == 8'd0) begin
          if (cyc != 8'd0) begin
            r.cycles_left = (cyc == FOREVER - 8'd1) ? FOREVER : cyc;
            r.ticks_left  = e.on_period;
            r.phase       = PH_ON;
          end else begin
            r.cycles_left = cyc;
            r.phase       = PH_IDLE;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mcbs_ram.sv
// ---------------------------------------------------------------------------
// mcbs_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module mcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/multi_channel_blink_sequencer.sv
// ---------------------------------------------------------------------------
// multi_channel_blink_sequencer
// on/off blink patterns for several channels, state kept in one memory
// ---------------------------------------------------------------------------
// start command: memory written at acceptance if the channel is in range,
//   then the done state registers the result once the output is free
// tick: read-modify-write sweep of the channel memory, one channel a cycle,
//   then the done state registers the result once the output is free
// next transaction accepted once back in idle, later while the result is stalled
// reset: per-entry valid bits make every channel idle at once, no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_channel_blink_sequencer_defines.svh"

module multi_channel_blink_sequencer
  import mcbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  seq_state_t          state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [CHANNELS-1:0] vld_r, vld_nxt;
  logic [CHANNELS-1:0] on_r, on_nxt;
  logic [CHANNELS-1:0] run_r, run_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic             in_acc;
  logic             ch_ok;
  logic [CH_W-1:0]  st_ch;
  logic             go;
  logic             last;
  logic             out_free;
  logic             ram_we;
  logic [CH_W-1:0]  ram_waddr;
  logic [CH_W-1:0]  ram_raddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  ent_t             cur;
  ent_t             upd;
  ent_t             st_ent;
  logic [LVL_W-1:0] levels;

  mcbs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_acc   = in_valid && !in_stall;
  assign ch_ok    = 32'(in_data.channel) < CHANNELS;
  assign st_ch    = in_data.channel[CH_W-1:0];
  assign go       = (in_data.on_ticks != 8'd0) && (in_data.repeat_total != 8'd0);
  assign last     = (ch_r == LAST_CH);
  assign out_free = !out_valid_r || !out_stall;
  assign cur      = vld_r[ch_r] ? ent_t'(ram_rdata) : '0;
  assign upd      = mcbs_advance(cur);

  always_comb begin
    st_ent = '0;
    if (go) begin
      st_ent.phase       = PH_ON;
      st_ent.ticks_left  = in_data.on_ticks;
      st_ent.on_period   = in_data.on_ticks;
      st_ent.off_period  = in_data.off_ticks;
      st_ent.cycles_left = in_data.repeat_total;
    end
  end

  for (genvar i = 0; i < LVL_W; i++) begin : g_lvl
    if (i < CHANNELS) begin : g_used
      assign levels[i] = on_r[i];
    end else begin : g_pad
      assign levels[i] = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.opcode == OP_TICK) ? SQ_SWEEP : SQ_DONE;
        end
      end
      SQ_SWEEP: begin
        if (last) begin
          state_nxt = SQ_DONE;
        end
      end
      SQ_DONE: begin
        if (out_free) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall      = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = ch_r;
    ram_wdata     = ENT_W'(upd);
    ram_raddr     = '0;
    ch_nxt        = ch_r;
    vld_nxt       = vld_r;
    on_nxt        = on_r;
    run_nxt       = run_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      SQ_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.opcode == OP_START && ch_ok) begin
          ram_we         = 1'b1;
          ram_waddr      = st_ch;
          ram_wdata      = ENT_W'(st_ent);
          vld_nxt[st_ch] = 1'b1;
          on_nxt[st_ch]  = go;
          run_nxt[st_ch] = go;
        end
      end
      SQ_SWEEP: begin
        ram_we        = 1'b1;
        ram_raddr     = last ? '0 : ch_r + CH_W'(1);
        ch_nxt        = last ? '0 : ch_r + CH_W'(1);
        vld_nxt[ch_r] = 1'b1;
        on_nxt[ch_r]  = (upd.phase == PH_ON);
        run_nxt[ch_r] = (upd.phase == PH_ON) || (upd.phase == PH_OFF);
      end
      SQ_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.output_levels = levels;
          out_data_nxt.any_active    = |run_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      ch_r        <= '0;
      vld_r       <= '0;
      on_r        <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      vld_r       <= vld_nxt;
      on_r        <= on_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MCBS_ASSERT(a_on_implies_run, (on_r & ~run_r) == '0)
  `MCBS_ASSERT(a_sweep_in_range, ch_r <= LAST_CH)
  `MCBS_ASSERT(a_sweep_ends, (state_r == SQ_SWEEP && last) |=> state_r == SQ_DONE)
  `MCBS_ASSERT(a_acc_leaves_idle, in_acc |=> state_r != SQ_IDLE)
  `MCBS_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == SQ_DONE))
  `MCBS_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid_r)

endmodule

`default_nettype wire
